### rtl/mmfs_pkg.sv
// shared types and constants of the min-max feature scaler
package mmfs_pkg;

  localparam int unsigned DefNumFeatures  = 64;
  localparam int unsigned DefFractionBits = 16;

  localparam int unsigned OpW    = 2;
  localparam int unsigned IndexW = 6;
  localparam int unsigned ValueW = 32;

  typedef enum logic [OpW-1:0] {
    OP_FIT       = 2'd0,
    OP_TRANSFORM = 2'd1,
    OP_READ      = 2'd2,
    OP_NONE      = 2'd3
  } op_e;

  // one queued request for the back end, bounds already fetched
  typedef struct packed {
    logic                     is_read;
    logic                     flat;
    logic signed [ValueW-1:0] sample;
    logic signed [ValueW-1:0] lo;
    logic signed [ValueW-1:0] hi;
  } entry_t;

endpackage

### rtl/mmfs_in_if.sv
// request channel of the min-max feature scaler
interface mmfs_in_if;
  logic                                    valid;
  logic                                    ready;
  logic [mmfs_pkg::OpW-1:0]                operation;
  logic                                    first_row;
  logic [mmfs_pkg::IndexW-1:0]             feature_index;
  logic signed [mmfs_pkg::ValueW-1:0]      sample_value;

  modport source (output valid, output operation, output first_row,
                  output feature_index, output sample_value, input ready);
  modport sink (input valid, input operation, input first_row,
                input feature_index, input sample_value, output ready);
endinterface

### rtl/mmfs_out_if.sv
// result channel of the min-max feature scaler
interface mmfs_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [mmfs_pkg::ValueW-1:0] result_value;
  logic                               unscaled;
  logic signed [mmfs_pkg::ValueW-1:0] low_bound;
  logic signed [mmfs_pkg::ValueW-1:0] high_bound;

  modport source (output valid, output result_value, output unscaled,
                  output low_bound, output high_bound, input ready);
  modport sink (input valid, input result_value, input unscaled,
                input low_bound, input high_bound, output ready);
endinterface

### rtl/mmfs_front.sv
// front end: accepts requests, owns the bound memories, handles fits
module mmfs_front #(
  parameter int unsigned FEATURE_COUNT = mmfs_pkg::DefNumFeatures
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  mmfs_in_if.sink           in_i,
  output logic              push_o,
  output mmfs_pkg::entry_t  push_data_o,
  input  logic              full_i,
  output logic              clearing_o
);

  localparam int unsigned AW = (FEATURE_COUNT > 1) ? $clog2(FEATURE_COUNT) : 1;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } state_e;

  state_e                            state_q;
  logic [AW-1:0]                     cnt_q;
  mmfs_pkg::op_e                     op_q;
  logic                              first_q;
  logic                              valid_q;
  logic [AW-1:0]                     addr_q;
  logic signed [mmfs_pkg::ValueW-1:0] val_q;

  logic signed [mmfs_pkg::ValueW-1:0] min_mem [FEATURE_COUNT];
  logic signed [mmfs_pkg::ValueW-1:0] max_mem [FEATURE_COUNT];
  logic signed [mmfs_pkg::ValueW-1:0] min_rd_q, max_rd_q;

  logic                               accept;
  logic [AW-1:0]                      rd_addr;
  logic signed [mmfs_pkg::ValueW-1:0] lo, hi;
  logic                               we;
  logic [AW-1:0]                      waddr;
  logic signed [mmfs_pkg::ValueW-1:0] wmin, wmax;

  assign in_i.ready  = (state_q == ST_IDLE);
  assign accept      = in_i.valid && in_i.ready;
  // keep reading the held request's entry while it waits for queue room
  assign rd_addr     = (state_q == ST_IDLE) ? AW'(in_i.feature_index) : addr_q;
  assign clearing_o  = (state_q == ST_CLEAR);

  // an index past the table reads as zero bounds
  assign lo = valid_q ? min_rd_q : '0;
  assign hi = valid_q ? max_rd_q : '0;

  always_comb begin
    we    = 1'b0;
    waddr = addr_q;
    wmin  = '0;
    wmax  = '0;
    if (state_q == ST_CLEAR) begin
      we    = 1'b1;
      waddr = cnt_q;
    end else if (state_q == ST_EXEC && op_q == mmfs_pkg::OP_FIT && valid_q) begin
      we = 1'b1;
      if (first_q) begin
        wmin = val_q;
        wmax = val_q;
      end else begin
        wmin = (val_q < lo) ? val_q : lo;
        wmax = (val_q > hi) ? val_q : hi;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      min_mem[waddr] <= wmin;
      max_mem[waddr] <= wmax;
    end
    min_rd_q <= min_mem[rd_addr];
    max_rd_q <= max_mem[rd_addr];
  end

  assign push_o = (state_q == ST_EXEC) && !full_i &&
                  (op_q == mmfs_pkg::OP_TRANSFORM || op_q == mmfs_pkg::OP_READ);
  assign push_data_o = '{is_read: (op_q == mmfs_pkg::OP_READ), flat: (lo == hi),
                         sample: val_q, lo: lo, hi: hi};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      cnt_q   <= '0;
      op_q    <= mmfs_pkg::OP_NONE;
      first_q <= 1'b0;
      valid_q <= 1'b0;
      addr_q  <= '0;
      val_q   <= '0;
    end else begin
      case (state_q)
        ST_CLEAR: begin
          if (cnt_q == AW'(FEATURE_COUNT - 1)) begin
            state_q <= ST_IDLE;
          end
          cnt_q <= cnt_q + 1'b1;
        end
        ST_IDLE: begin
          if (accept) begin
            op_q    <= mmfs_pkg::op_e'(in_i.operation);
            first_q <= in_i.first_row;
            valid_q <= (32'(in_i.feature_index) < 32'(FEATURE_COUNT));
            addr_q  <= rd_addr;
            val_q   <= in_i.sample_value;
            state_q <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          // queued requests wait here for room
          if (push_o || !(op_q == mmfs_pkg::OP_TRANSFORM || op_q == mmfs_pkg::OP_READ)) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

### rtl/mmfs_queue.sv
// two-entry queue between front and back end
module mmfs_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  mmfs_pkg::entry_t push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output mmfs_pkg::entry_t pop_data_o,
  output logic             empty_o
);

  mmfs_pkg::entry_t mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  assign full_o     = (cnt_q == 2'd2);
  assign empty_o    = (cnt_q == 2'd0);
  assign pop_data_o = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) begin
        wr_q <= ~wr_q;
      end
      if (pop_i) begin
        rd_q <= ~rd_q;
      end
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

endmodule

### rtl/mmfs_back.sv
// back end: bit-serial scaling division, saturation and result register
module mmfs_back #(
  parameter int unsigned FRACTION_BITS = mmfs_pkg::DefFractionBits
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  mmfs_pkg::entry_t pop_data_i,
  input  logic             empty_i,
  output logic             pop_o,
  mmfs_out_if.source       out_o
);

  localparam int unsigned VW    = mmfs_pkg::ValueW;
  localparam int unsigned DW    = VW + 1;
  localparam int unsigned DVD_W = DW + FRACTION_BITS;
  localparam int unsigned REM_W = DW + 1;
  localparam int unsigned CNT_W = $clog2(DVD_W);

  typedef enum logic [1:0] {
    B_IDLE,
    B_DIV,
    B_FIN,
    B_OUT
  } state_e;

  state_e                state_q;
  logic [DVD_W-1:0]      dvd_q;
  logic [REM_W-1:0]      rem_q;
  logic [DW-1:0]         ad_q;
  logic                  neg_q;
  logic [CNT_W-1:0]      cnt_q;
  logic signed [VW-1:0]  res_q, lo_q, hi_q;
  logic                  flat_q;

  logic signed [DW-1:0]  num, den;
  logic [DW-1:0]         an, ad;
  logic [REM_W-1:0]      rem_sh;
  logic [REM_W:0]        diff;
  logic                  ge;

  assign num = DW'(pop_data_i.sample) - DW'(pop_data_i.lo);
  assign den = DW'(pop_data_i.hi) - DW'(pop_data_i.lo);
  assign an  = num[DW-1] ? DW'(-num) : DW'(num);
  assign ad  = den[DW-1] ? DW'(-den) : DW'(den);

  // one restoring step per cycle, quotient shifts in behind the dividend
  assign rem_sh = {rem_q[REM_W-2:0], dvd_q[DVD_W-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, ad_q};
  assign ge     = !diff[REM_W];

  assign pop_o              = (state_q == B_IDLE) && !empty_i;
  assign out_o.valid        = (state_q == B_OUT);
  assign out_o.result_value = res_q;
  assign out_o.unscaled     = flat_q;
  assign out_o.low_bound    = lo_q;
  assign out_o.high_bound   = hi_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
      dvd_q   <= '0;
      rem_q   <= '0;
      ad_q    <= '0;
      neg_q   <= 1'b0;
      cnt_q   <= '0;
      res_q   <= '0;
      lo_q    <= '0;
      hi_q    <= '0;
      flat_q  <= 1'b0;
    end else begin
      case (state_q)
        B_IDLE: begin
          if (pop_o) begin
            lo_q   <= pop_data_i.lo;
            hi_q   <= pop_data_i.hi;
            flat_q <= pop_data_i.flat;
            if (pop_data_i.is_read) begin
              res_q   <= '0;
              state_q <= B_OUT;
            end else if (pop_data_i.flat) begin
              res_q   <= pop_data_i.sample;
              state_q <= B_OUT;
            end else begin
              dvd_q   <= {an, FRACTION_BITS'(0)};
              rem_q   <= '0;
              ad_q    <= ad;
              neg_q   <= num[DW-1] ^ den[DW-1];
              cnt_q   <= '0;
              state_q <= B_DIV;
            end
          end
        end
        B_DIV: begin
          rem_q <= ge ? diff[REM_W-1:0] : rem_sh;
          dvd_q <= {dvd_q[DVD_W-2:0], ge};
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CNT_W'(DVD_W - 1)) begin
            state_q <= B_FIN;
          end
        end
        B_FIN: begin
          if (neg_q) begin
            res_q <= (dvd_q > DVD_W'(33'h0_8000_0000)) ? 32'sh8000_0000
                                                       : -$signed(dvd_q[VW-1:0]);
          end else begin
            res_q <= (dvd_q > DVD_W'(33'h0_7fff_ffff)) ? 32'sh7fff_ffff
                                                       : $signed(dvd_q[VW-1:0]);
          end
          state_q <= B_OUT;
        end
        B_OUT: begin
          if (out_o.ready) begin
            state_q <= B_IDLE;
          end
        end
        default: state_q <= B_IDLE;
      endcase
    end
  end

endmodule

### rtl/min_max_feature_scaler.sv
// top level of the min-max feature scaler
// Per-feature min-max normalizer. Requests arrive on in_i: a fit (operation 0)
// loads or widens the stored minimum and maximum of a feature and gives no
// result; a transform (1) returns (value-min)/(max-min) in signed fixed point
// with FRACTION_BITS fraction bits, saturated to 32 bits, or the raw value
// with unscaled set when max equals min; a read (2) returns the bounds and
// the flag with a zero result. Code 3 is dropped.
// The front end holds in_i.ready low while it handles a request and passes
// transforms and reads into a two-entry queue. A transform goes through the
// front end's execute state, a pop from the queue, the one-bit-per-cycle
// divider and a saturation step before its result shows on out_o; the back
// end takes no new entry until out_o has taken the last result. Reads and
// flat transforms skip the divider and the saturation step.
// After reset the front end writes zero to every bound entry and holds
// in_i.ready low until that pass is done.
// When out_o is stalled the result register holds, the back end stops, and
// the front end keeps taking requests until the queue is full and a
// transform or read waits in the front end; fits only wait behind such one.
module min_max_feature_scaler #(
  parameter int unsigned FEATURE_COUNT = mmfs_pkg::DefNumFeatures,
  parameter int unsigned FRACTION_BITS = mmfs_pkg::DefFractionBits
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  mmfs_in_if.sink   in_i,
  mmfs_out_if.source out_o
);

  logic             push, pop, full, empty, clearing;
  mmfs_pkg::entry_t push_data, pop_data;

  mmfs_front #(.FEATURE_COUNT(FEATURE_COUNT)) u_front (
    .clk_i, .rst_ni, .in_i,
    .push_o(push), .push_data_o(push_data), .full_i(full), .clearing_o(clearing)
  );

  mmfs_queue u_queue (
    .clk_i, .rst_ni,
    .push_i(push), .push_data_i(push_data), .full_o(full),
    .pop_i(pop), .pop_data_o(pop_data), .empty_o(empty)
  );

  mmfs_back #(.FRACTION_BITS(FRACTION_BITS)) u_back (
    .clk_i, .rst_ni, .pop_data_i(pop_data), .empty_i(empty), .pop_o(pop), .out_o
  );

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push && full && !pop)) else $error("queue overflow");

  a_no_accept_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing |-> !in_i.ready) else $error("request taken during clear");

  a_flag_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.unscaled == (out_o.low_bound == out_o.high_bound)))
    else $error("unscaled flag mismatch");

  a_bounds_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.low_bound <= out_o.high_bound))
    else $error("minimum above maximum");

endmodule
